[sv/gql_pkg.sv]
// shared types, constants and saturation helper for the glyph quad layout block
package gql_pkg;

  localparam int GLYPH_COUNT    = 256;
  localparam int GLYPH_IDX_BITS = $clog2(GLYPH_COUNT);
  localparam int CODE_BITS      = 8;
  localparam int COORD_BITS     = 24;
  // headroom for pen + width*256 + extra advance and (top - rows)*256 + line
  localparam int CALC_BITS      = ((COORD_BITS > 21) ? COORD_BITS : 21) + 2;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = Q_PTR_BITS + 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [15:0] FONT_SIZE_RESET = 16'd4096;

  typedef enum logic [1:0] {
    REG_FONT_SIZE     = 2'd0,
    REG_EXTRA_ADVANCE = 2'd1,
    REG_FLIP_Y        = 2'd2
  } reg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CALC_BITS-1:0]  calc_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [15:0]        tl;
    logic [15:0]        tt;
    logic [15:0]        tr;
    logic [15:0]        tb;
    logic [10:0]        width;
    logic [10:0]        rows;
    logic signed [11:0] top;
  } glyph_t;

  typedef struct packed {
    logic   newline;
    logic   start;
    glyph_t glyph;
  } qent_t;

  typedef struct packed {
    logic [15:0]        font_size;
    logic signed [15:0] extra_advance;
    logic               flip_y;
  } cfg_t;

  typedef struct packed {
    coord_t      x_left;
    coord_t      x_right;
    coord_t      y_first;
    coord_t      y_second;
    logic [15:0] tex_left;
    logic [15:0] tex_top;
    logic [15:0] tex_right;
    logic [15:0] tex_bottom;
    coord_t      box_min_x;
    coord_t      box_min_y;
    coord_t      box_max_x;
    coord_t      box_max_y;
  } quad_t;

  function automatic coord_t sat(input calc_t v);
    if (v > calc_t'(COORD_MAX)) begin
      return COORD_MAX;
    end else if (v < calc_t'(COORD_MIN)) begin
      return COORD_MIN;
    end else begin
      return coord_t'(v);
    end
  endfunction

endpackage

[sv/gql_front.sv]
// front end: item intake, glyph table writes and lookups
module gql_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [gql_pkg::CODE_BITS-1:0]       char_code,
  input  logic                                start_of_string,
  input  gql_pkg::glyph_t                     load_glyph,
  input  logic [gql_pkg::Q_CNT_BITS-1:0]      q_count,
  output logic                                push,
  output gql_pkg::qent_t                      push_data
);

  gql_pkg::glyph_t                          mem [gql_pkg::GLYPH_COUNT];
  logic [gql_pkg::GLYPH_COUNT-1:0]          vld;
  gql_pkg::glyph_t                          rd;
  logic                                     f1_valid;
  logic                                     f1_newline;
  logic                                     f1_start;
  logic                                     f1_hit;
  logic                                     accept;
  logic                                     in_range;
  logic                                     do_load;
  logic                                     do_place;
  logic [gql_pkg::GLYPH_IDX_BITS-1:0]       idx;

  // credit check: items in the lookup stage plus queued items must fit
  assign in_stall = ((gql_pkg::Q_CNT_BITS+1)'(q_count) + (gql_pkg::Q_CNT_BITS+1)'(f1_valid))
                    >= (gql_pkg::Q_CNT_BITS+1)'(gql_pkg::Q_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign in_range = {1'b0, char_code} < (gql_pkg::CODE_BITS+1)'(gql_pkg::GLYPH_COUNT);
  assign idx      = char_code[gql_pkg::GLYPH_IDX_BITS-1:0];
  assign do_load  = accept && (opcode == gql_pkg::OP_LOAD) && in_range;
  assign do_place = accept && (opcode == gql_pkg::OP_PLACE);

  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[idx] <= load_glyph;
    end
    if (do_place) begin
      rd <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (do_place) begin
      f1_newline <= (char_code == gql_pkg::NEWLINE_CODE);
      f1_start   <= start_of_string;
      f1_hit     <= in_range && vld[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= do_place;
      if (do_load) begin
        vld[idx] <= 1'b1;
      end
    end
  end

  // entries never written read as zero
  assign push              = f1_valid;
  assign push_data.newline = f1_newline;
  assign push_data.start   = f1_start;
  assign push_data.glyph   = f1_hit ? rd : '0;

endmodule

[sv/gql_queue.sv]
// small fifo between the lookup front end and the layout back end
module gql_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  gql_pkg::qent_t                  push_data,
  input  logic                            pop,
  output gql_pkg::qent_t                  head,
  output logic                            not_empty,
  output logic [gql_pkg::Q_CNT_BITS-1:0]  count
);

  gql_pkg::qent_t                   slots [gql_pkg::Q_DEPTH];
  logic [gql_pkg::Q_PTR_BITS-1:0]   wr_ptr;
  logic [gql_pkg::Q_PTR_BITS-1:0]   rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gql_pkg::Q_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gql_pkg::Q_PTR_BITS'(1);
      end
      count <= count + gql_pkg::Q_CNT_BITS'(push) - gql_pkg::Q_CNT_BITS'(pop);
    end
  end

endmodule

[sv/gql_back.sv]
// back end: pen and line tracking, quad coordinates, y flip and bounding box
module gql_back (
  input  logic              clk,
  input  logic              rst,
  input  gql_pkg::cfg_t     cfg,
  input  logic              q_not_empty,
  input  gql_pkg::qent_t    head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output gql_pkg::quad_t    quad
);

  gql_pkg::coord_t  pen;
  gql_pkg::coord_t  line;
  gql_pkg::coord_t  pen_next;
  gql_pkg::coord_t  line_next;
  gql_pkg::coord_t  pen_base;
  gql_pkg::coord_t  line_base;

  gql_pkg::calc_t   pen_ext;
  gql_pkg::calc_t   line_ext;
  gql_pkg::calc_t   wsc;
  gql_pkg::calc_t   top_sc;
  gql_pkg::calc_t   rows_sc;
  gql_pkg::calc_t   extra_ext;
  gql_pkg::calc_t   fs_ext;

  logic             b1_valid;
  logic             b1_result;
  logic             b1_start;
  gql_pkg::coord_t  b1_xl;
  gql_pkg::coord_t  b1_xr;
  gql_pkg::coord_t  b1_yf;
  gql_pkg::coord_t  b1_ys;
  logic [15:0]      b1_tl;
  logic [15:0]      b1_tt;
  logic [15:0]      b1_tr;
  logic [15:0]      b1_tb;

  gql_pkg::coord_t  yf_fin;
  gql_pkg::coord_t  ys_fin;
  gql_pkg::coord_t  box_min_x;
  gql_pkg::coord_t  box_min_y;
  gql_pkg::coord_t  box_max_x;
  gql_pkg::coord_t  box_max_y;
  gql_pkg::coord_t  base_min_x;
  gql_pkg::coord_t  base_min_y;
  gql_pkg::coord_t  base_max_x;
  gql_pkg::coord_t  base_max_y;
  gql_pkg::coord_t  new_min_x;
  gql_pkg::coord_t  new_min_y;
  gql_pkg::coord_t  new_max_x;
  gql_pkg::coord_t  new_max_y;

  logic             out_free;
  logic             b1_adv;

  assign out_free = !out_valid || !out_stall;
  assign b1_adv   = !b1_valid || out_free;
  assign pop      = q_not_empty && b1_adv;

  // stage one: pen and line offset, unflipped coordinates
  assign pen_base  = head.start ? '0 : pen;
  assign line_base = head.start ? '0 : line;
  assign pen_ext   = gql_pkg::calc_t'(pen_base);
  assign line_ext  = gql_pkg::calc_t'(line_base);
  assign wsc       = gql_pkg::calc_t'({head.glyph.width, 8'h00});
  assign rows_sc   = gql_pkg::calc_t'({head.glyph.rows, 8'h00});
  assign top_sc    = gql_pkg::calc_t'($signed({head.glyph.top, 8'h00}));
  assign extra_ext = gql_pkg::calc_t'(cfg.extra_advance);
  assign fs_ext    = gql_pkg::calc_t'(cfg.font_size);

  always_comb begin
    pen_next  = pen;
    line_next = line;
    if (pop) begin
      if (head.newline) begin
        pen_next  = '0;
        line_next = gql_pkg::sat(line_ext + fs_ext);
      end else begin
        pen_next  = gql_pkg::sat(pen_ext + wsc + extra_ext);
        line_next = line_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_result <= !head.newline;
      b1_start  <= head.start;
      b1_xl     <= pen_base;
      b1_xr     <= gql_pkg::sat(pen_ext + wsc);
      b1_yf     <= gql_pkg::sat(top_sc + line_ext);
      b1_ys     <= gql_pkg::sat(top_sc - rows_sc + line_ext);
      b1_tl     <= head.glyph.tl;
      b1_tt     <= head.glyph.tt;
      b1_tr     <= head.glyph.tr;
      b1_tb     <= head.glyph.tb;
    end
  end

  // stage two: flip and running box
  assign yf_fin = cfg.flip_y ? gql_pkg::sat(fs_ext - gql_pkg::calc_t'(b1_yf)) : b1_yf;
  assign ys_fin = cfg.flip_y ? gql_pkg::sat(fs_ext - gql_pkg::calc_t'(b1_ys)) : b1_ys;

  assign base_min_x = b1_start ? gql_pkg::COORD_MAX : box_min_x;
  assign base_min_y = b1_start ? gql_pkg::COORD_MAX : box_min_y;
  assign base_max_x = b1_start ? gql_pkg::COORD_MIN : box_max_x;
  assign base_max_y = b1_start ? gql_pkg::COORD_MIN : box_max_y;

  assign new_min_x = (b1_xl  < base_min_x) ? b1_xl  : base_min_x;
  assign new_min_y = (yf_fin < base_min_y) ? yf_fin : base_min_y;
  assign new_max_x = (b1_xr  > base_max_x) ? b1_xr  : base_max_x;
  assign new_max_y = (ys_fin > base_max_y) ? ys_fin : base_max_y;

  always_ff @(posedge clk) begin
    if (b1_valid && b1_result && out_free) begin
      quad.x_left     <= b1_xl;
      quad.x_right    <= b1_xr;
      quad.y_first    <= yf_fin;
      quad.y_second   <= ys_fin;
      quad.tex_left   <= b1_tl;
      quad.tex_top    <= b1_tt;
      quad.tex_right  <= b1_tr;
      quad.tex_bottom <= b1_tb;
      quad.box_min_x  <= new_min_x;
      quad.box_min_y  <= new_min_y;
      quad.box_max_x  <= new_max_x;
      quad.box_max_y  <= new_max_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen       <= '0;
      line      <= '0;
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
      box_min_x <= gql_pkg::COORD_MAX;
      box_min_y <= gql_pkg::COORD_MAX;
      box_max_x <= gql_pkg::COORD_MIN;
      box_max_y <= gql_pkg::COORD_MIN;
    end else begin
      pen  <= pen_next;
      line <= line_next;
      if (b1_adv) begin
        b1_valid <= q_not_empty;
      end
      if (out_free) begin
        out_valid <= b1_valid && b1_result;
      end
      if (b1_valid && out_free) begin
        if (b1_result) begin
          box_min_x <= new_min_x;
          box_min_y <= new_min_y;
          box_max_x <= new_max_x;
          box_max_y <= new_max_y;
        end else begin
          box_min_x <= base_min_x;
          box_min_y <= base_min_y;
          box_max_x <= base_max_x;
          box_max_y <= base_max_y;
        end
      end
    end
  end

endmodule

[sv/glyph_quad_layout.sv]
// top level of the glyph quad layout block
// Bitmap font text layout, one item per clock. A load item (opcode 0) writes
// the glyph table entry picked by char_code; a place item (opcode 1) looks up
// its glyph and, unless it is a newline, yields one quad with saturating
// Q16.8 coordinates, the glyph's texture corners and the running bounding box
// of the string. A newline returns the pen to zero and steps the line offset
// by font_size with no result; start_of_string on a place item clears pen,
// line offset and box first. Items are taken at one per cycle for as long as
// out_stall allows: the front end does the glyph table access (one registered
// read or write per cycle), a four-entry queue decouples it from the back end,
// and the back end carries pen and line offset in an add loop, then applies the
// y flip and box update in a second stage before the output register. A place
// item passes the lookup, queue, stage-one and output registers; in_stall rises
// only once the queue backs up. Glyph table entries read as zero until loaded;
// no clearing pass is needed after reset. Configuration (index 0 font_size, 1
// extra_advance, 2 flip_y) is written through cfg_write/cfg_index/cfg_data by
// the user only while the block is idle; the block does not enforce this.
module glyph_quad_layout (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write,
  input  logic [1:0]                            cfg_index,
  input  logic [15:0]                           cfg_data,
  // input item channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  opcode,
  input  logic [7:0]                            char_code,
  input  logic                                  start_of_string,
  input  logic [15:0]                           tex_left_in,
  input  logic [15:0]                           tex_top_in,
  input  logic [15:0]                           tex_right_in,
  input  logic [15:0]                           tex_bottom_in,
  input  logic [10:0]                           glyph_width,
  input  logic [10:0]                           glyph_rows,
  input  logic signed [11:0]                    glyph_top,
  // result item channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gql_pkg::COORD_BITS-1:0] x_left,
  output logic signed [gql_pkg::COORD_BITS-1:0] x_right,
  output logic signed [gql_pkg::COORD_BITS-1:0] y_first,
  output logic signed [gql_pkg::COORD_BITS-1:0] y_second,
  output logic [15:0]                           tex_left,
  output logic [15:0]                           tex_top,
  output logic [15:0]                           tex_right,
  output logic [15:0]                           tex_bottom,
  output logic signed [gql_pkg::COORD_BITS-1:0] box_min_x,
  output logic signed [gql_pkg::COORD_BITS-1:0] box_min_y,
  output logic signed [gql_pkg::COORD_BITS-1:0] box_max_x,
  output logic signed [gql_pkg::COORD_BITS-1:0] box_max_y
);

  gql_pkg::cfg_t                        cfg;
  gql_pkg::glyph_t                      load_glyph;
  gql_pkg::qent_t                       push_data;
  gql_pkg::qent_t                       head;
  gql_pkg::quad_t                       quad;
  logic                                 push;
  logic                                 pop;
  logic                                 q_not_empty;
  logic [gql_pkg::Q_CNT_BITS-1:0]       q_count;

  // configuration registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.font_size     <= gql_pkg::FONT_SIZE_RESET;
      cfg.extra_advance <= '0;
      cfg.flip_y        <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        gql_pkg::REG_FONT_SIZE:     cfg.font_size     <= cfg_data;
        gql_pkg::REG_EXTRA_ADVANCE: cfg.extra_advance <= $signed(cfg_data);
        gql_pkg::REG_FLIP_Y:        cfg.flip_y        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // glyph fields of a load item
  assign load_glyph.tl    = tex_left_in;
  assign load_glyph.tt    = tex_top_in;
  assign load_glyph.tr    = tex_right_in;
  assign load_glyph.tb    = tex_bottom_in;
  assign load_glyph.width = glyph_width;
  assign load_glyph.rows  = glyph_rows;
  assign load_glyph.top   = glyph_top;

  gql_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .char_code       (char_code),
    .start_of_string (start_of_string),
    .load_glyph      (load_glyph),
    .q_count         (q_count),
    .push            (push),
    .push_data       (push_data)
  );

  gql_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  gql_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .quad        (quad)
  );

  // result fields
  assign x_left     = quad.x_left;
  assign x_right    = quad.x_right;
  assign y_first    = quad.y_first;
  assign y_second   = quad.y_second;
  assign tex_left   = quad.tex_left;
  assign tex_top    = quad.tex_top;
  assign tex_right  = quad.tex_right;
  assign tex_bottom = quad.tex_bottom;
  assign box_min_x  = quad.box_min_x;
  assign box_min_y  = quad.box_min_y;
  assign box_max_x  = quad.box_max_x;
  assign box_max_y  = quad.box_max_y;

endmodule

[test/glyph_quad_layout_tb.sv]
// self-checking testbench for the glyph quad layout block
`timescale 1ns / 100ps

// directed table first, then five random phases, each under its own register
// setting; every accepted item runs through a local predictor and every
// accepted quad is compared field by field with the oldest predicted quad
module glyph_quad_layout_tb;

  localparam int SETTLE_CYCLES   = 12;      // slack after the last quad is out
  localparam int HOLD_OFF_CYCLES = 64;      // long receiver hold-off
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam int HOLD_OFF_PHASE  = 1;       // phase that gets the long hold-off
  localparam int PAUSE_PHASE     = 3;       // phase where the sender waits for all quads

  localparam longint COORD_TOP    = (longint'(1) <<< (gql_pkg::COORD_BITS - 1)) - 1;
  localparam longint COORD_BOTTOM = -COORD_TOP - 1;

  // register index past the end of the list, must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum {DRAIN_FREE, DRAIN_SOME, DRAIN_HEAVY} drain_mode_t;

  typedef struct packed {
    logic            opcode;
    logic [7:0]      code;
    logic            start;
    gql_pkg::glyph_t glyph;
  } text_item_t;

  // one item plus an optional hand-written expected quad
  typedef struct packed {
    text_item_t     item;
    logic           pinned;
    gql_pkg::quad_t quad;
  } text_row_t;

  typedef struct packed {
    logic [15:0] font;
    logic [15:0] extra;
    logic        flip;
    logic        rand_cfg;
    int          count;
    int          start_pct;
    int          nl_pct;
    int          load_pct;
    int          wild_pct;
    int          max_width;
    int          pool_lo;
    int          pool_n;
  } phase_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic [7:0]         char_code;
  logic               start_of_string;
  logic [15:0]        tex_left_in;
  logic [15:0]        tex_top_in;
  logic [15:0]        tex_right_in;
  logic [15:0]        tex_bottom_in;
  logic [10:0]        glyph_width;
  logic [10:0]        glyph_rows;
  logic signed [11:0] glyph_top;
  logic               out_valid;
  logic               out_stall;
  gql_pkg::coord_t    x_left;
  gql_pkg::coord_t    x_right;
  gql_pkg::coord_t    y_first;
  gql_pkg::coord_t    y_second;
  logic [15:0]        tex_left;
  logic [15:0]        tex_top;
  logic [15:0]        tex_right;
  logic [15:0]        tex_bottom;
  gql_pkg::coord_t    box_min_x;
  gql_pkg::coord_t    box_min_y;
  gql_pkg::coord_t    box_max_x;
  gql_pkg::coord_t    box_max_y;

  text_row_t      cur_row;
  gql_pkg::quad_t got_quad;

  // predictor state: glyph table, string state and register copies
  gql_pkg::glyph_t glyph_tab [gql_pkg::GLYPH_COUNT];
  longint pen_pos;
  longint line_pos;
  longint box_lo_x;
  longint box_lo_y;
  longint box_hi_x;
  longint box_hi_y;
  longint pitch_cfg;
  longint advance_cfg;
  logic   mirror_cfg;

  gql_pkg::quad_t quads_due [$];
  text_row_t      dir_rows [$];
  phase_t         phase_plan [5];
  int             mismatches = 0;
  int             burst_left = 0;
  logic           hold_off_req = 1'b0;

  glyph_quad_layout dut (.*);

  // the item fields all come from one row register, changed at the falling edge
  assign opcode          = cur_row.item.opcode;
  assign char_code       = cur_row.item.code;
  assign start_of_string = cur_row.item.start;
  assign tex_left_in     = cur_row.item.glyph.tl;
  assign tex_top_in      = cur_row.item.glyph.tt;
  assign tex_right_in    = cur_row.item.glyph.tr;
  assign tex_bottom_in   = cur_row.item.glyph.tb;
  assign glyph_width     = cur_row.item.glyph.width;
  assign glyph_rows      = cur_row.item.glyph.rows;
  assign glyph_top       = cur_row.item.glyph.top;

  assign got_quad = {x_left, x_right, y_first, y_second,
                     tex_left, tex_top, tex_right, tex_bottom,
                     box_min_x, box_min_y, box_max_x, box_max_y};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_TOP) return COORD_TOP;
    if (v < COORD_BOTTOM) return COORD_BOTTOM;
    return v;
  endfunction

  // pen, line and box back to the start-of-string values
  function automatic void restart_string();
    pen_pos  = 0;
    line_pos = 0;
    box_lo_x = COORD_TOP;
    box_lo_y = COORD_TOP;
    box_hi_x = COORD_BOTTOM;
    box_hi_y = COORD_BOTTOM;
  endfunction

  // applies one item to the predictor state; returns 1 with the quad it yields
  function automatic logic lay_out(input text_item_t it, output gql_pkg::quad_t q);
    gql_pkg::glyph_t g;
    longint w;
    longint rows;
    longint tp;
    longint xl;
    longint xr;
    longint yf;
    longint ys;
    q = '0;
    if (it.opcode == gql_pkg::OP_LOAD) begin
      // start flag on a load is ignored
      glyph_tab[it.code] = it.glyph;
      return 1'b0;
    end
    if (it.start) restart_string();
    if (it.code == gql_pkg::NEWLINE_CODE) begin
      pen_pos  = 0;
      line_pos = clamp_coord(line_pos + pitch_cfg);
      return 1'b0;
    end
    g    = glyph_tab[it.code];
    w    = g.width;
    rows = g.rows;
    tp   = $signed(g.top);
    xl   = pen_pos;
    xr   = clamp_coord(xl + w * 256);
    yf   = clamp_coord(tp * 256 + line_pos);
    ys   = clamp_coord((tp - rows) * 256 + line_pos);
    if (mirror_cfg) begin
      yf = clamp_coord(pitch_cfg - yf);
      ys = clamp_coord(pitch_cfg - ys);
    end
    if (xl < box_lo_x) box_lo_x = xl;
    if (yf < box_lo_y) box_lo_y = yf;
    if (xr > box_hi_x) box_hi_x = xr;
    if (ys > box_hi_y) box_hi_y = ys;
    q.x_left     = gql_pkg::coord_t'(xl);
    q.x_right    = gql_pkg::coord_t'(xr);
    q.y_first    = gql_pkg::coord_t'(yf);
    q.y_second   = gql_pkg::coord_t'(ys);
    q.tex_left   = g.tl;
    q.tex_top    = g.tt;
    q.tex_right  = g.tr;
    q.tex_bottom = g.tb;
    q.box_min_x  = gql_pkg::coord_t'(box_lo_x);
    q.box_min_y  = gql_pkg::coord_t'(box_lo_y);
    q.box_max_x  = gql_pkg::coord_t'(box_hi_x);
    q.box_max_y  = gql_pkg::coord_t'(box_hi_y);
    pen_pos = clamp_coord(pen_pos + w * 256 + advance_cfg);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_quad(input gql_pkg::quad_t want, input gql_pkg::quad_t got);
    check_field("x_left", want.x_left, got.x_left);
    check_field("x_right", want.x_right, got.x_right);
    check_field("y_first", want.y_first, got.y_first);
    check_field("y_second", want.y_second, got.y_second);
    check_field("tex_left", want.tex_left, got.tex_left);
    check_field("tex_top", want.tex_top, got.tex_top);
    check_field("tex_right", want.tex_right, got.tex_right);
    check_field("tex_bottom", want.tex_bottom, got.tex_bottom);
    check_field("box_min_x", want.box_min_x, got.box_min_x);
    check_field("box_min_y", want.box_min_y, got.box_min_y);
    check_field("box_max_x", want.box_max_x, got.box_max_x);
    check_field("box_max_y", want.box_max_y, got.box_max_y);
  endtask

  // one process handles both sides so the quad queue has a single owner
  always @(posedge clk) begin
    gql_pkg::quad_t want;
    gql_pkg::quad_t next_quad;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (quads_due.size() == 0) begin
          $error("quad received with none expected");
          mismatches++;
        end else begin
          want = quads_due.pop_front();
          check_quad(want, got_quad);
        end
      end
      if (in_valid && !in_stall) begin
        if (lay_out(cur_row.item, next_quad)) begin
          // a hand-written quad replaces the predicted one
          quads_due.push_back(cur_row.pinned ? cur_row.quad : next_quad);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // stall pattern in segments of random mode and length, plus one long
  // hold-off on request that fills the block and backs up its input
  initial begin
    int          hold_left;
    int          mode_left;
    drain_mode_t drain_mode;
    hold_left  = 0;
    mode_left  = 0;
    drain_mode = DRAIN_FREE;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          drain_mode = drain_mode_t'($urandom_range(0, 2));
          mode_left  = $urandom_range(4, 40);
        end
        mode_left--;
        case (drain_mode)
          DRAIN_FREE: out_stall <= 1'b0;
          DRAIN_SOME: out_stall <= ($urandom_range(0, 3) == 0);
          default:    out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // offers one item inside a burst, with a random gap between bursts
  task automatic send_row(input text_row_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cur_row  <= row;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_quads_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (quads_due.size() != 0) @(posedge clk);
  endtask

  // idle point: nothing expected and loads or newlines flushed out
  task automatic settle();
    wait_quads_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      gql_pkg::REG_FONT_SIZE:     pitch_cfg = data;
      gql_pkg::REG_EXTRA_ADVANCE: advance_cfg = $signed(data);
      gql_pkg::REG_FLIP_Y:        mirror_cfg = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic text_row_t load_row(input int code, input int tl, input int tt,
                                         input int tr, input int tb, input int w,
                                         input int rows, input int top, input logic start);
    text_row_t row;
    row = '0;
    row.item.opcode       = gql_pkg::OP_LOAD;
    row.item.code         = 8'(code);
    row.item.start        = start;
    row.item.glyph.tl     = 16'(tl);
    row.item.glyph.tt     = 16'(tt);
    row.item.glyph.tr     = 16'(tr);
    row.item.glyph.tb     = 16'(tb);
    row.item.glyph.width  = 11'(w);
    row.item.glyph.rows   = 11'(rows);
    row.item.glyph.top    = 12'(top);
    return row;
  endfunction

  function automatic text_row_t place_row(input int code, input logic start);
    text_row_t row;
    row = '0;
    row.item.opcode = gql_pkg::OP_PLACE;
    row.item.code   = 8'(code);
    row.item.start  = start;
    return row;
  endfunction

  function automatic text_row_t pinned_row(input int code, input logic start,
                                           input gql_pkg::quad_t q);
    text_row_t row;
    row        = place_row(code, start);
    row.pinned = 1'b1;
    row.quad   = q;
    return row;
  endfunction

  function automatic gql_pkg::glyph_t rand_glyph(input int max_width);
    gql_pkg::glyph_t g;
    g.tl    = 16'($urandom);
    g.tt    = 16'($urandom);
    g.tr    = 16'($urandom);
    g.tb    = 16'($urandom);
    g.width = 11'($urandom_range(0, max_width));
    g.rows  = 11'($urandom);
    g.top   = 12'($urandom);
    return g;
  endfunction

  // mostly places and newlines on the phase's glyph pool, some loads and
  // stray codes; start flags on loads are noise
  function automatic text_item_t rand_item(input phase_t ph);
    text_item_t it;
    it.glyph = rand_glyph(ph.max_width);
    it.start = 1'($urandom);
    if ($urandom_range(0, 99) < ph.wild_pct) begin
      it.code = 8'($urandom);
    end else begin
      it.code = 8'(ph.pool_lo + $urandom_range(0, ph.pool_n - 1));
    end
    if ($urandom_range(0, 99) < ph.load_pct) begin
      it.opcode = gql_pkg::OP_LOAD;
    end else begin
      it.opcode = gql_pkg::OP_PLACE;
      it.start  = ($urandom_range(0, 99) < ph.start_pct);
      if ($urandom_range(0, 99) < ph.nl_pct) it.code = gql_pkg::NEWLINE_CODE;
    end
    return it;
  endfunction

  initial begin
    text_row_t      row;
    phase_t         ph;
    gql_pkg::quad_t widest;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    cur_row   = '0;
    foreach (glyph_tab[i]) glyph_tab[i] = '0;
    restart_string();
    pitch_cfg   = gql_pkg::FONT_SIZE_RESET;
    advance_cfg = 0;
    mirror_cfg  = 1'b0;

    // widest glyph at the string start: full width, full rows, lowest top
    widest = '0;
    widest.x_right    = gql_pkg::coord_t'(2047 * 256);
    widest.y_first    = gql_pkg::coord_t'(-2048 * 256);
    widest.y_second   = gql_pkg::coord_t'(-4095 * 256);
    widest.tex_left   = 16'hFFFF;
    widest.tex_top    = 16'hFFFF;
    widest.tex_right  = 16'hFFFF;
    widest.tex_bottom = 16'hFFFF;
    widest.box_min_y  = gql_pkg::coord_t'(-2048 * 256);
    widest.box_max_x  = gql_pkg::coord_t'(2047 * 256);
    widest.box_max_y  = gql_pkg::coord_t'(-4095 * 256);

    // directed table, register values at their reset settings
    // never-loaded glyph right after reset gives an all-zero quad and box
    dir_rows.push_back(pinned_row(65, 1'b1, '0));
    // start flag on a load is ignored
    dir_rows.push_back(load_row(200, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                2047, 2047, -2048, 1'b1));
    dir_rows.push_back(pinned_row(200, 1'b1, widest));
    dir_rows.push_back(load_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(load_row(1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 10, 16, 12, 1'b0));
    dir_rows.push_back(load_row(2, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE, 7, 0, 2047, 1'b0));
    dir_rows.push_back(load_row(255, 16'hA5A5, 16'h5A5A, 16'h00FF, 16'hFF00,
                                1, 2047, -1, 1'b1));
    dir_rows.push_back(place_row(1, 1'b0));
    dir_rows.push_back(place_row(gql_pkg::NEWLINE_CODE, 1'b0));
    dir_rows.push_back(place_row(2, 1'b0));
    dir_rows.push_back(place_row(255, 1'b0));
    // start on a newline clears first, then steps the line
    dir_rows.push_back(place_row(gql_pkg::NEWLINE_CODE, 1'b1));
    dir_rows.push_back(place_row(1, 1'b0));
    dir_rows.push_back(place_row(0, 1'b0));
    // a glyph loaded at the newline code never shows up as a quad
    dir_rows.push_back(load_row(gql_pkg::NEWLINE_CODE, 100, 100, 100, 100, 100, 100, 100,
                                1'b0));
    dir_rows.push_back(place_row(gql_pkg::NEWLINE_CODE, 1'b0));
    dir_rows.push_back(place_row(200, 1'b0));
    dir_rows.push_back(place_row(200, 1'b0));
    dir_rows.push_back(place_row(2, 1'b1));
    dir_rows.push_back(place_row(128, 1'b0));
    dir_rows.push_back(place_row(255, 1'b0));

    // font, extra, flip, rand_cfg, count, start%, newline%, load%, stray%,
    // max width, pool base, pool size
    // newline-heavy lines at the largest pitch drive the line offset to its top
    phase_plan[0] = '{16'hFFFF, 16'h7FFF, 1'b1, 1'b0, 160, 0, 90, 0, 10, 2047, 32, 16};
    // long strings with the largest advance saturate the pen upward
    phase_plan[1] = '{16'h0000, 16'h7FFF, 1'b0, 1'b0, 50, 3, 2, 10, 10, 2047, 96, 16};
    // one string of narrow glyphs at the most negative advance runs the pen
    // into its lower limit
    phase_plan[2] = '{16'h0000, 16'h8000, 1'b1, 1'b0, 270, 0, 0, 0, 0, 1, 0, 4};
    phase_plan[3] = '{16'h0000, 16'h0000, 1'b0, 1'b1, 40, 10, 10, 20, 10, 2047, 200, 16};
    phase_plan[4] = '{16'h0001, 16'h0001, 1'b0, 1'b0, 30, 15, 15, 20, 10, 2047, 240, 16};

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_row(dir_rows[i]);
    settle();

    foreach (phase_plan[p]) begin
      ph = phase_plan[p];
      if (ph.rand_cfg) begin
        ph.font  = 16'($urandom);
        ph.extra = 16'($urandom);
        ph.flip  = 1'($urandom);
      end
      write_reg(gql_pkg::REG_FONT_SIZE, ph.font);
      write_reg(gql_pkg::REG_EXTRA_ADVANCE, ph.extra);
      write_reg(gql_pkg::REG_FLIP_Y, {15'($urandom), ph.flip});
      // unused index last, so a bad decode would clobber a live register
      write_reg(REG_UNUSED, 16'($urandom));

      // load the phase's glyph pool, then lay out text on it
      for (int k = 0; k < ph.pool_n; k++) begin
        row = '0;
        row.item.opcode = gql_pkg::OP_LOAD;
        row.item.code   = 8'(ph.pool_lo + k);
        row.item.start  = 1'($urandom);
        row.item.glyph  = rand_glyph(ph.max_width);
        send_row(row);
      end

      if (p == HOLD_OFF_PHASE) hold_off_req = 1'b1;

      for (int i = 0; i < ph.count; i++) begin
        // sender holds back until every quad so far has come out
        if (p == PAUSE_PHASE && i == ph.count / 2) wait_quads_done();
        row = '0;
        row.item = rand_item(ph);
        if (i == 0) begin
          row.item.opcode = gql_pkg::OP_PLACE;
          row.item.start  = 1'b1;
          row.item.code   = 8'(ph.pool_lo);
        end
        send_row(row);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
